>>> design/ttps_pkg.sv
// Shared types and constants for the transposition table probe/store block.
// Used by ttps_probe_eval and transposition_table_probe_store; no dependencies.

package ttps_pkg;

    // Table depth; must be a power of two so the slot is the low key bits.
    localparam int unsigned TABLE_ENTRIES = 65536;
    localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned PLY_W   = 6;
    localparam int unsigned DEPTH_W = 6;
    localparam int unsigned FLAG_W  = 2;
    localparam int unsigned SCORE_W = 17;
    localparam int unsigned ESC_W   = 18;   // stored score, room for ply push
    localparam int unsigned MT_W    = 16;

    localparam logic [MT_W-1:0] MATE_THRESHOLD_RST = MT_W'(48000);

    localparam logic OP_PROBE = 1'b0;
    localparam logic OP_STORE = 1'b1;

    typedef enum logic [FLAG_W-1:0] {
        FLAG_EXACT = 2'd0,
        FLAG_UPPER = 2'd1,
        FLAG_LOWER = 2'd2
    } flag_t;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [DEPTH_W-1:0]        depth;
        logic [FLAG_W-1:0]         flag;
        logic signed [ESC_W-1:0]   score;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } ctl_state_t;

    // Probe request fields held while the table read is in flight.
    typedef struct packed {
        logic                      op;
        logic [KEY_W-1:0]          key;
        logic [PLY_W-1:0]          ply;
        logic [DEPTH_W-1:0]        depth;
        logic signed [SCORE_W-1:0] alpha;
        logic signed [SCORE_W-1:0] beta;
    } probe_req_t;

endpackage

>>> design/transposition_table_probe_store.sv
// Transposition table probe/store, direct mapped, always replace.
// Path: an accepted beat goes through the read stage, then the output register.
// Throughput: one request per cycle while in_stall is low; set by the single table RAM,
// which takes either one read (probe) or one write (store) per cycle.
// Reset: mate_threshold returns to 48000, then a clearing sweep writes every
// entry to zero, one per cycle (TABLE_ENTRIES = 65536 entries), with in_stall high.

module transposition_table_probe_store (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ttps_pkg::MT_W-1:0]            cfg_data,
    // request channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 op,
    input  logic [ttps_pkg::KEY_W-1:0]           position_key,
    input  logic [ttps_pkg::PLY_W-1:0]           search_ply,
    input  logic [ttps_pkg::DEPTH_W-1:0]         search_depth,
    input  logic signed [ttps_pkg::SCORE_W-1:0]  alpha_bound,
    input  logic signed [ttps_pkg::SCORE_W-1:0]  beta_bound,
    input  logic signed [ttps_pkg::SCORE_W-1:0]  store_score,
    input  logic [ttps_pkg::FLAG_W-1:0]          store_flag,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 hit,
    output logic signed [ttps_pkg::SCORE_W-1:0]  result_score
);

    localparam logic [ttps_pkg::IDX_W-1:0] LAST_IDX =
        ttps_pkg::IDX_W'(ttps_pkg::TABLE_ENTRIES - 1);

    // ------------------------------------------------------------------
    // Control state: clearing sweep after reset, then normal operation.
    // ------------------------------------------------------------------
    ttps_pkg::ctl_state_t state_reg, state_next;
    logic [ttps_pkg::IDX_W-1:0] clr_idx_reg, clr_idx_next;
    logic clr_active;

    // Mate threshold register
    logic [ttps_pkg::MT_W-1:0] mt_reg, mt_next;

    // Read stage: request held while table read data comes back
    logic                 s1_valid_reg, s1_valid_next;
    ttps_pkg::probe_req_t s1_req_reg, s1_req_next;

    // Output register
    logic                                 out_valid_reg, out_valid_next;
    logic                                 hit_reg, hit_next;
    logic signed [ttps_pkg::SCORE_W-1:0]  score_reg, score_next;

    logic in_acc;
    logic s1_adv;

    // Table RAM ports
    logic                            ram_we;
    logic [ttps_pkg::IDX_W-1:0]      ram_waddr;
    ttps_pkg::entry_t                ram_wentry;
    logic                            ram_re;
    ttps_pkg::entry_t                rd_entry;
    logic [ttps_pkg::ENTRY_W-1:0]    rd_bits;

    // Store score push-out
    logic signed [18:0] st_mt_pos;
    logic signed [18:0] st_mt_neg;
    logic signed [18:0] st_ply;
    logic signed [18:0] st_s0;
    logic signed [18:0] st_s1;
    logic signed [18:0] st_s2;

    // Probe evaluation
    logic                                ev_hit;
    logic signed [ttps_pkg::SCORE_W-1:0] ev_score;

    // ------------------------------------------------------------------
    // State machine: next state and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        unique case (state_reg)
            ttps_pkg::ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = ttps_pkg::ST_RUN;
                end
            end
            ttps_pkg::ST_RUN:
            begin
                state_next = ttps_pkg::ST_RUN;
            end
            default:
            begin
                state_next = ttps_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            ttps_pkg::ST_CLEAR: clr_active = 1'b1;
            ttps_pkg::ST_RUN:   clr_active = 1'b0;
            default:            clr_active = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshakes. The read stage moves on when the output register is
    // empty or being drained; hold the input while the read stage is stuck
    // so the RAM read data stays put, and during the clearing sweep.
    // ------------------------------------------------------------------
    assign s1_adv    = !out_valid_reg || !out_stall;
    assign in_stall  = clr_active || (s1_valid_reg && !s1_adv);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        mt_next = mt_reg;
        if (cfg_valid)
        begin
            mt_next = cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Store path: push mate scores away from zero by ply before writing.
    // ------------------------------------------------------------------
    always_comb
    begin
        st_mt_pos = signed'({3'b000, mt_reg});
        st_mt_neg = -st_mt_pos;
        st_ply    = signed'({13'd0, search_ply});
        st_s0     = signed'({{2{store_score[ttps_pkg::SCORE_W-1]}}, store_score});
        st_s1     = (st_s0 < st_mt_neg) ? (st_s0 - st_ply) : st_s0;
        st_s2     = (st_s1 > st_mt_pos) ? (st_s1 + st_ply) : st_s1;
    end

    // RAM write: clearing sweep or a store beat; read: a probe beat.
    always_comb
    begin
        if (clr_active)
        begin
            ram_we     = 1'b1;
            ram_waddr  = clr_idx_reg;
            ram_wentry = '0;
        end
        else
        begin
            ram_we           = in_acc && (op == ttps_pkg::OP_STORE);
            ram_waddr        = position_key[ttps_pkg::IDX_W-1:0];
            ram_wentry.key   = position_key;
            ram_wentry.depth = search_depth;
            ram_wentry.flag  = store_flag;
            ram_wentry.score = st_s2[ttps_pkg::ESC_W-1:0];
        end
        ram_re = in_acc && (op == ttps_pkg::OP_PROBE);
    end

    ttps_ram #(
        .WIDTH (ttps_pkg::ENTRY_W),
        .DEPTH (ttps_pkg::TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .re    (ram_re),
        .raddr (position_key[ttps_pkg::IDX_W-1:0]),
        .rdata (rd_bits)
    );

    assign rd_entry = ttps_pkg::entry_t'(rd_bits);

    // ------------------------------------------------------------------
    // Read stage: capture the request alongside the RAM read.
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_req_next   = s1_req_reg;
        if (!s1_valid_reg || s1_adv)
        begin
            s1_valid_next = in_acc;
        end
        if (in_acc)
        begin
            s1_req_next.op    = op;
            s1_req_next.key   = position_key;
            s1_req_next.ply   = search_ply;
            s1_req_next.depth = search_depth;
            s1_req_next.alpha = alpha_bound;
            s1_req_next.beta  = beta_bound;
        end
    end

    ttps_probe_eval u_eval (
        .entry          (rd_entry),
        .req            (s1_req_reg),
        .mate_threshold (mt_reg),
        .hit            (ev_hit),
        .score          (ev_score)
    );

    // ------------------------------------------------------------------
    // Output register: load from the read stage, drop when taken.
    // A store beat reports a miss with score zero.
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        score_next     = score_reg;
        if (s1_valid_reg && s1_adv)
        begin
            out_valid_next = 1'b1;
            if (s1_req_reg.op == ttps_pkg::OP_STORE)
            begin
                hit_next   = 1'b0;
                score_next = '0;
            end
            else
            begin
                hit_next   = ev_hit;
                score_next = ev_score;
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign result_score = score_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttps_pkg::ST_CLEAR;
            clr_idx_reg   <= '0;
            mt_reg        <= ttps_pkg::MATE_THRESHOLD_RST;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            mt_reg        <= mt_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_req_reg <= s1_req_next;
        hit_reg    <= hit_next;
        score_reg  <= score_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A stuck read stage must see the same RAM data next cycle.
    a_rdata_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> $stable(rd_bits))
        else $error("table read data changed under a stalled read stage");

    // The sweep hands over to normal operation right after the last entry.
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ttps_pkg::ST_CLEAR && clr_idx_reg == LAST_IDX)
        |=> (state_reg == ttps_pkg::ST_RUN))
        else $error("clearing sweep did not finish after the last entry");

    // A store beat leaving the read stage yields a miss with score zero.
    a_store_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_adv && s1_req_reg.op == ttps_pkg::OP_STORE)
        |=> (out_valid_reg && !hit_reg && score_reg == '0))
        else $error("store beat produced a non-zero result");

    // No request reaches the table while the sweep owns the write port.
    a_no_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active |-> !(ram_re || s1_valid_next))
        else $error("request accepted during clearing sweep");

endmodule

>>> design/ttps_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered; no dependencies.

module ttps_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/ttps_probe_eval.sv
// Probe evaluation: key/depth match, mate-score pull-back, bound check.
// Depends on ttps_pkg.

module ttps_probe_eval (
    input  ttps_pkg::entry_t                       entry,
    input  ttps_pkg::probe_req_t                   req,
    input  logic [ttps_pkg::MT_W-1:0]              mate_threshold,
    output logic                                   hit,
    output logic signed [ttps_pkg::SCORE_W-1:0]    score
);

    logic signed [18:0] mt_pos;
    logic signed [18:0] mt_neg;
    logic signed [18:0] ply_s;
    logic signed [18:0] s0;
    logic signed [18:0] s1;
    logic signed [18:0] s2;
    logic signed [ttps_pkg::SCORE_W-1:0] s_sat;
    logic match;

    always_comb
    begin
        mt_pos = signed'({3'b000, mate_threshold});
        mt_neg = -mt_pos;
        ply_s  = signed'({13'd0, req.ply});
        s0     = signed'({entry.score[ttps_pkg::ESC_W-1], entry.score});

        // Pull mate scores back toward zero; both checks apply in turn.
        s1 = (s0 < mt_neg) ? (s0 + ply_s) : s0;
        s2 = (s1 > mt_pos) ? (s1 - ply_s) : s1;

        if (s2 > 19'sd65535)
        begin
            s_sat = 17'sd65535;
        end
        else if (s2 < -19'sd65536)
        begin
            s_sat = -17'sd65536;
        end
        else
        begin
            s_sat = s2[ttps_pkg::SCORE_W-1:0];
        end

        match = (entry.key == req.key) && (entry.depth >= req.depth);
        hit   = 1'b0;
        score = '0;
        if (match)
        begin
            priority if (entry.flag == ttps_pkg::FLAG_EXACT)
            begin
                hit   = 1'b1;
                score = s_sat;
            end
            else if (entry.flag == ttps_pkg::FLAG_UPPER && s_sat <= req.alpha)
            begin
                hit   = 1'b1;
                score = req.alpha;
            end
            else if (entry.flag == ttps_pkg::FLAG_LOWER && s_sat >= req.beta)
            begin
                hit   = 1'b1;
                score = req.beta;
            end
            else
            begin
                hit   = 1'b0;
                score = '0;
            end
        end
    end

endmodule

>>> test/transposition_table_probe_store_test.sv
// Self-checking testbench for transposition_table_probe_store: directed and random
// probe/store traffic checked against a behavioral mirror of the table.
// Depends on ttps_pkg and the transposition_table_probe_store RTL.

module transposition_table_probe_store_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 8;
    // Clearing sweep of all 65536 entries plus a slow run of ~1200 beats; taken many times over.
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 8;
    localparam int KEY_POOL     = 40;

    localparam int SCORE_MAX = 2 ** (ttps_pkg::SCORE_W - 1) - 1;
    localparam int SCORE_MIN = -(2 ** (ttps_pkg::SCORE_W - 1));

    // Bound type with no meaning; stored as given, never hits.
    localparam logic [ttps_pkg::FLAG_W-1:0] FLAG_UNUSED = 2'd3;

    typedef struct {
        logic                                op;
        logic [ttps_pkg::KEY_W-1:0]          key;
        logic [ttps_pkg::PLY_W-1:0]          ply;
        logic [ttps_pkg::DEPTH_W-1:0]        depth;
        logic signed [ttps_pkg::SCORE_W-1:0] alpha;
        logic signed [ttps_pkg::SCORE_W-1:0] beta;
        logic signed [ttps_pkg::SCORE_W-1:0] score;
        logic [ttps_pkg::FLAG_W-1:0]         flag;
    } tt_request_t;

    typedef struct {
        logic                                hit;
        logic signed [ttps_pkg::SCORE_W-1:0] score;
    } tt_reply_t;

    // Mirror of the table: applies every accepted request beat in order and
    // queues the reply the block owes for it.
    class tt_mirror;
        bit [ttps_pkg::KEY_W-1:0]   slot_key   [ttps_pkg::TABLE_ENTRIES];
        bit [ttps_pkg::DEPTH_W-1:0] slot_depth [ttps_pkg::TABLE_ENTRIES];
        bit [ttps_pkg::FLAG_W-1:0]  slot_flag  [ttps_pkg::TABLE_ENTRIES];
        int                         slot_score [ttps_pkg::TABLE_ENTRIES];
        logic [ttps_pkg::MT_W-1:0]  threshold;
        tt_reply_t                  pending_replies[$];
        int                         failures;

        function new();
            threshold = ttps_pkg::MATE_THRESHOLD_RST;
            failures  = 0;
        endfunction

        function void note_request(tt_request_t r);
            int unsigned slot;
            int          mt;
            int          ply;
            int          s;
            tt_reply_t   rep;
            slot      = int'(r.key[ttps_pkg::IDX_W-1:0]);
            mt        = int'(threshold);
            ply       = int'(r.ply);
            rep.hit   = 1'b0;
            rep.score = '0;
            if (r.op == ttps_pkg::OP_STORE) begin
                // Push mate scores away from zero by ply.
                s = r.score;
                if (s < -mt) s = s - ply;
                if (s > mt)  s = s + ply;
                slot_key[slot]   = r.key;
                slot_depth[slot] = r.depth;
                slot_flag[slot]  = r.flag;
                slot_score[slot] = s;
            end else if (slot_key[slot] == r.key && slot_depth[slot] >= r.depth) begin
                // Pull mate scores back toward zero, sequentially, then clamp.
                s = slot_score[slot];
                if (s < -mt) s = s + ply;
                if (s > mt)  s = s - ply;
                if (s > SCORE_MAX) s = SCORE_MAX;
                if (s < SCORE_MIN) s = SCORE_MIN;
                case (slot_flag[slot])
                    ttps_pkg::FLAG_EXACT: begin
                        rep.hit   = 1'b1;
                        rep.score = ttps_pkg::SCORE_W'(s);
                    end
                    ttps_pkg::FLAG_UPPER: if (s <= int'(r.alpha)) begin
                        rep.hit   = 1'b1;
                        rep.score = r.alpha;
                    end
                    ttps_pkg::FLAG_LOWER: if (s >= int'(r.beta)) begin
                        rep.hit   = 1'b1;
                        rep.score = r.beta;
                    end
                    default: ;
                endcase
            end
            pending_replies.push_back(rep);
        endfunction

        function void check_reply(logic got_hit,
                                  logic signed [ttps_pkg::SCORE_W-1:0] got_score);
            tt_reply_t want;
            if (pending_replies.size() == 0) begin
                $error("result beat with no request outstanding: hit %0d result_score %0d",
                       got_hit, got_score);
                failures++;
                return;
            end
            want = pending_replies.pop_front();
            if (got_hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, got_hit);
                failures++;
            end
            if (got_score !== want.score) begin
                $error("result_score: expected %0d, got %0d", want.score, got_score);
                failures++;
            end
        endfunction
    endclass

    logic                                clk;
    logic                                rst_n        = 1'b0;
    logic                                cfg_valid    = 1'b0;
    logic                                cfg_ready;
    logic [ttps_pkg::MT_W-1:0]           cfg_data     = '0;
    logic                                in_valid     = 1'b0;
    logic                                in_stall;
    logic                                op           = ttps_pkg::OP_PROBE;
    logic [ttps_pkg::KEY_W-1:0]          position_key = '0;
    logic [ttps_pkg::PLY_W-1:0]          search_ply   = '0;
    logic [ttps_pkg::DEPTH_W-1:0]        search_depth = '0;
    logic signed [ttps_pkg::SCORE_W-1:0] alpha_bound  = '0;
    logic signed [ttps_pkg::SCORE_W-1:0] beta_bound   = '0;
    logic signed [ttps_pkg::SCORE_W-1:0] store_score  = '0;
    logic [ttps_pkg::FLAG_W-1:0]         store_flag   = '0;
    logic                                out_valid;
    logic                                out_stall    = 1'b0;
    logic                                hit;
    logic signed [ttps_pkg::SCORE_W-1:0] result_score;

    tt_mirror                   mirror;
    logic [ttps_pkg::KEY_W-1:0] key_pool [KEY_POOL];

    // Sender and receiver pacing, retuned per phase.
    int gap_max      = 2;
    int burst_max    = 4;
    int stall_pct    = 25;
    int burst_left   = 0;
    bit hold_request = 1'b0;

    int unsigned cycle_count = 0;

    transposition_table_probe_store uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .position_key (position_key),
        .search_ply   (search_ply),
        .search_depth (search_depth),
        .alpha_bound  (alpha_bound),
        .beta_bound   (beta_bound),
        .store_score  (store_score),
        .store_flag   (store_flag),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .result_score (result_score)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Watchdog: the clearing sweep after reset is inside this budget.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("transposition_table_probe_store test failed");
            $finish;
        end
    end

    // Check every result beat; sampled values are the pre-edge ones.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            mirror.check_reply(hit, result_score);
    end

    // Receiver: stall in runs of random length, or hold off for a long
    // stretch on request so the block backs up into its input.
    initial
    begin : result_receiver
        int   run_left;
        int   hold_left;
        logic stalling;
        run_left  = 0;
        hold_left = 0;
        stalling  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_left = $urandom_range(1, 12);
                    stalling = ($urandom_range(99) < stall_pct);
                end
                run_left--;
                out_stall <= stalling;
            end
        end
    end

    // Score near the interesting points: the mate threshold on both sides,
    // the field extremes, small values, or anywhere in the field.
    function automatic logic signed [ttps_pkg::SCORE_W-1:0] random_score(int mt);
        int v;
        case ($urandom_range(0, 4))
            0:       v = int'($urandom);
            1:       v = mt + int'($urandom_range(0, 8)) - 4;
            2:       v = -mt + int'($urandom_range(0, 8)) - 4;
            3:       v = int'($urandom_range(0, 2000)) - 1000;
            default:
                case ($urandom_range(0, 3))
                    0:       v = SCORE_MAX;
                    1:       v = SCORE_MIN;
                    2:       v = 50000;
                    default: v = -50000;
                endcase
        endcase
        return ttps_pkg::SCORE_W'(v);
    endfunction

    // Mostly stores and probes on a small key pool so probes find entries;
    // the rest are keys drawn from the whole field.
    function automatic tt_request_t random_request();
        tt_request_t r;
        int          mt;
        mt      = int'(mirror.threshold);
        r.op    = ($urandom_range(99) < 40) ? ttps_pkg::OP_STORE : ttps_pkg::OP_PROBE;
        r.key   = ($urandom_range(99) < 85) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                            : {$urandom, $urandom};
        r.ply   = ttps_pkg::PLY_W'($urandom);
        r.depth = ($urandom_range(99) < 70) ? ttps_pkg::DEPTH_W'($urandom_range(0, 12))
                                            : ttps_pkg::DEPTH_W'($urandom);
        r.alpha = random_score(mt);
        r.beta  = random_score(mt);
        r.score = random_score(mt);
        r.flag  = ($urandom_range(99) < 6) ? FLAG_UNUSED
                                           : ttps_pkg::FLAG_W'($urandom_range(0, 2));
        return r;
    endfunction

    // Present one request beat and hold it until accepted. Bursts of random
    // length are separated by random gaps.
    task automatic offer_request(input tt_request_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, burst_max);
            gap        = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        op           <= r.op;
        position_key <= r.key;
        search_ply   <= r.ply;
        search_depth <= r.depth;
        alpha_bound  <= r.alpha;
        beta_bound   <= r.beta;
        store_score  <= r.score;
        store_flag   <= r.flag;
        do @(posedge clk); while (in_stall !== 1'b0);
        mirror.note_request(r);
    endtask

    // Unused fields stay random; the block must ignore them.
    task automatic store_entry(input logic [ttps_pkg::KEY_W-1:0] key, input int ply,
                               input int depth, input int score,
                               input logic [ttps_pkg::FLAG_W-1:0] flag);
        tt_request_t r;
        r       = random_request();
        r.op    = ttps_pkg::OP_STORE;
        r.key   = key;
        r.ply   = ttps_pkg::PLY_W'(ply);
        r.depth = ttps_pkg::DEPTH_W'(depth);
        r.score = ttps_pkg::SCORE_W'(score);
        r.flag  = flag;
        offer_request(r);
    endtask

    task automatic probe_entry(input logic [ttps_pkg::KEY_W-1:0] key, input int ply,
                               input int depth, input int alpha, input int beta);
        tt_request_t r;
        r       = random_request();
        r.op    = ttps_pkg::OP_PROBE;
        r.key   = key;
        r.ply   = ttps_pkg::PLY_W'(ply);
        r.depth = ttps_pkg::DEPTH_W'(depth);
        r.alpha = ttps_pkg::SCORE_W'(alpha);
        r.beta  = ttps_pkg::SCORE_W'(beta);
        offer_request(r);
    endtask

    // Drop valid and wait for every outstanding result beat.
    task automatic drain_replies();
        in_valid  <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (mirror.pending_replies.size() != 0);
    endtask

    task automatic write_threshold(input logic [ttps_pkg::MT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        mirror.threshold = value;
    endtask

    // One random phase under one threshold. Halfway through, optionally
    // hold off the receiver or pause the sender until the block is empty.
    task automatic run_phase(input logic [ttps_pkg::MT_W-1:0] mt, input int count,
                             input int gaps, input int bursts, input int stall,
                             input bit with_hold, input bit with_pause);
        drain_replies();
        write_threshold(mt);
        gap_max   = gaps;
        burst_max = bursts;
        stall_pct = stall;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
            begin
                if (with_hold)
                    hold_request = 1'b1;
                if (with_pause)
                    drain_replies();
            end
            offer_request(random_request());
        end
    endtask

    initial
    begin : stimulus
        logic [ttps_pkg::KEY_W-1:0] ka;
        logic [ttps_pkg::KEY_W-1:0] kb;
        logic [ttps_pkg::KEY_W-1:0] kc;
        logic [ttps_pkg::KEY_W-1:0] kd;
        logic [ttps_pkg::KEY_W-1:0] ke;
        logic [ttps_pkg::KEY_W-1:0] kf;
        mirror = new();

        // Key pool: zero, all ones, random keys, then keys that share a
        // slot with an earlier pool key but differ in the upper bits.
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 24; i++)
            key_pool[i] = {$urandom, $urandom};
        for (int i = 24; i < KEY_POOL; i++)
            key_pool[i] = {$urandom, 16'($urandom),
                           key_pool[i - 22][ttps_pkg::IDX_W-1:0]};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset threshold. The first beats wait out
        // the clearing sweep through in_stall.
        ka = '1;
        kb = 64'h0123_4567_89AB_CDEF;
        kc = 64'h8000_0000_0000_1234;
        kd = 64'h5A5A_A5A5_0F0F_F0F0;
        ke = 64'h7FFF_FFFF_FFFF_8000;
        kf = 64'h0000_0000_0000_8001;

        // Cleared entry: key zero at depth zero hits with score zero.
        probe_entry('0, 0, 0, 0, 0);
        probe_entry('0, 0, 1, 0, 0);
        // Same slot, different upper key bits: miss.
        probe_entry(64'h8000_0000_0000_0000, 0, 0, 0, 0);

        // Mate score pushed out on store and pulled back on probe.
        store_entry(ka, 63, 63, 50000, ttps_pkg::FLAG_EXACT);
        probe_entry(ka, 63, 63, 0, 0);
        probe_entry(ka, 0, 0, 0, 0);

        // Upper bound: alpha returned at or below alpha, miss otherwise.
        store_entry(kb, 10, 5, -50000, ttps_pkg::FLAG_UPPER);
        probe_entry(kb, 10, 5, -40000, 0);
        probe_entry(kb, 10, 6, -40000, 0);
        probe_entry(kb, 10, 0, SCORE_MIN, 0);
        probe_entry(kb, 10, 0, -50000, 0);

        // Lower bound: beta returned at or above beta.
        store_entry(kc, 0, 20, 30000, ttps_pkg::FLAG_LOWER);
        probe_entry(kc, 0, 20, 0, 30000);
        probe_entry(kc, 0, 20, 0, 30001);
        probe_entry(kc, 0, 0, 0, SCORE_MAX);
        probe_entry(kc, 0, 0, 0, SCORE_MIN);

        // Unused bound type: stored, never hits.
        store_entry(kd, 0, 0, 100, FLAG_UNUSED);
        probe_entry(kd, 0, 0, SCORE_MAX, SCORE_MIN);

        // Saturation of the adjusted score on both sides.
        store_entry(ke, 63, 40, SCORE_MAX, ttps_pkg::FLAG_EXACT);
        probe_entry(ke, 0, 40, 0, 0);
        store_entry(kf, 63, 40, SCORE_MIN, ttps_pkg::FLAG_EXACT);
        probe_entry(kf, 0, 40, 0, 0);

        // Always replace: an aliasing key evicts the earlier entry.
        store_entry(ka ^ (64'd1 << 40), 0, 3, -7, ttps_pkg::FLAG_EXACT);
        probe_entry(ka, 0, 0, 0, 0);
        probe_entry(ka ^ (64'd1 << 40), 0, 3, 0, 0);

        // Random phases across the threshold range, extremes included.
        run_phase(ttps_pkg::MT_W'(0),        200, 0,  16, 0,  1'b0, 1'b0);
        run_phase(ttps_pkg::MT_W'(50000),    200, 6,  6,  30, 1'b1, 1'b0);
        run_phase(ttps_pkg::MT_W'(65535),    200, 3,  8,  50, 1'b0, 1'b0);
        run_phase(ttps_pkg::MT_W'($urandom), 200, 10, 4,  20, 1'b0, 1'b1);
        run_phase(ttps_pkg::MATE_THRESHOLD_RST, 200, 2, 10, 60, 1'b1, 1'b0);
        run_phase(ttps_pkg::MT_W'($urandom_range(0, 50000)), 150, 4, 5, 35, 1'b0, 1'b0);

        // Let the last beats out, then watch for strays.
        drain_replies();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mirror.failures == 0 && mirror.pending_replies.size() == 0)
            $display("transposition_table_probe_store test passed");
        else
            $display("transposition_table_probe_store test failed");
        $finish;
    end

endmodule
